[sv/ftss_pkg.sv]
package ftss_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int TOKEN_BITS  = 32;

    // Widths fixed by the beat formats.
    localparam int REQ_W      = 3;
    localparam int DEPTH_IN_W = 6;
    localparam int TOKEN_W    = 32;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    // Room for a requested depth and for the count plus one.
    localparam int TGT_W = ((CNT_W > DEPTH_IN_W) ? CNT_W : DEPTH_IN_W) + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_FEED   = 3'd0,
        REQ_CALL   = 3'd1,
        REQ_RETURN = 3'd2,
        REQ_CHAIN  = 3'd3,
        REQ_RESET  = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_TOP_RD,
        ST_TOP_OUT,
        ST_CHAIN_RD,
        ST_CHAIN_OUT,
        ST_NONE_OUT
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [DEPTH_IN_W-1:0] call_depth;
    } t_in_beat;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic               has_token;
        logic               is_last;
        logic               overflow;
    } t_out_beat;

endpackage

[sv/ftss_ram.sv]
module ftss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/frame_token_shadow_stack.sv]
// A call pushes an entry, checks the count, reads the top entry and then emits it.
// A feed pops, then pushes, reads and emits; return, reset and others read, then emit.
// A chain query reads each entry from memory, then emits it, before it reads the next.
// One request is handled at a time; the input stalls until its last beat is loaded.
// Reset empties the stack and sets the serial to one; the memory is not cleared.
module frame_token_shadow_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ftss_pkg::t_in_beat i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ftss_pkg::t_out_beat o_out
);

    import ftss_pkg::*;

    // Control state.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TOKEN_BITS-1:0] r_serial, n_serial;
    logic [TGT_W-1:0]     r_target, n_target;
    logic                 r_ovf, n_ovf;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    // Memory port controls.
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [TOKEN_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [TOKEN_BITS-1:0] mem_rdata;

    logic                  out_free;
    logic [TGT_W-1:0]      feed_depth;
    logic [TGT_W-1:0]      count_ext;

    // The token stack lives in a single memory: entries below the count are live.
    ftss_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (STACK_DEPTH),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // The output register can take a new beat when it is empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign count_ext  = TGT_W'(r_count);
    // A reported depth of zero counts as one.
    assign feed_depth = (i_in.call_depth == '0) ? TGT_W'(1) : TGT_W'(i_in.call_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_serial    <= TOKEN_BITS'(1);
            r_target    <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_serial    <= n_serial;
            r_target    <= n_target;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // The output beat is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_serial    = r_serial;
        n_target    = r_target;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_count[IDX_W-1:0];
        mem_wdata   = r_serial;
        mem_re      = 1'b0;
        mem_raddr   = IDX_W'(r_count - CNT_W'(1));

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ovf = 1'b0;
                    case (i_in.req_type)
                        REQ_FEED: begin
                            // Popping down to the depth is only a count change.
                            if (count_ext > feed_depth) begin
                                n_count = CNT_W'(feed_depth);
                            end
                            n_target = feed_depth;
                            n_state  = ST_PUSH;
                        end
                        REQ_CALL: begin
                            n_target = count_ext + TGT_W'(1);
                            n_state  = ST_PUSH;
                        end
                        REQ_RETURN: begin
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                            n_state = ST_TOP_RD;
                        end
                        REQ_CHAIN: begin
                            n_idx = '0;
                            if (r_count < CNT_W'(2)) begin
                                n_state = ST_NONE_OUT;
                            end else begin
                                n_state = ST_CHAIN_RD;
                            end
                        end
                        REQ_RESET: begin
                            n_count  = '0;
                            n_serial = TOKEN_BITS'(1);
                            n_state  = ST_TOP_RD;
                        end
                        default: begin
                            n_state = ST_TOP_RD;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                // One entry is written per cycle until the target is reached or the
                // stack is full, in which case the remaining pushes are dropped.
                if (count_ext < r_target) begin
                    if (r_count < CNT_W'(STACK_DEPTH)) begin
                        mem_we   = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                        n_serial = r_serial + TOKEN_BITS'(1);
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = ST_TOP_RD;
                    end
                end else begin
                    n_state = ST_TOP_RD;
                end
            end
            ST_TOP_RD: begin
                mem_re  = (r_count != '0);
                n_state = ST_TOP_OUT;
            end
            ST_TOP_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.token     = (r_count != '0) ? TOKEN_W'(mem_rdata) : '0;
                    n_out.has_token = (r_count != '0);
                    n_out.is_last   = 1'b1;
                    n_out.overflow  = r_ovf;
                    n_state         = ST_IDLE;
                end
            end
            ST_CHAIN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = ST_CHAIN_OUT;
            end
            ST_CHAIN_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.token     = TOKEN_W'(mem_rdata);
                    n_out.has_token = 1'b1;
                    n_out.overflow  = 1'b0;
                    // The chain stops one below the top entry.
                    if (r_idx == IDX_W'(r_count - CNT_W'(2))) begin
                        n_out.is_last = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_out.is_last = 1'b0;
                        n_idx         = r_idx + IDX_W'(1);
                        n_state       = ST_CHAIN_RD;
                    end
                end
            end
            ST_NONE_OUT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.token     = '0;
                    n_out.has_token = 1'b0;
                    n_out.is_last   = 1'b1;
                    n_out.overflow  = 1'b0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
